### src/frmr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// frmr_pkg
// Shared constants for the fraction max and reduce block.
// ============================================================================
package frmr_pkg;

    // default word width of numerators and denominators
    localparam int WORD_BITS_DEF = 32;

endpackage

### src/frmr_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// frmr_divider
// Iterative signed divider, one quotient bit per cycle, C truncating rules:
// quotient rounds toward zero, remainder takes the sign of the dividend.
// ============================================================================
module frmr_divider #(
    parameter int WORD_BITS = frmr_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [WORD_BITS-1:0] i_dividend,
    input  logic signed [WORD_BITS-1:0] i_divisor,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_quotient,
    output logic signed [WORD_BITS-1:0] o_remainder
);

    localparam int CntBits = $clog2(WORD_BITS);

    logic                 r_active;
    logic                 r_done;
    logic [CntBits-1:0]   r_cnt;
    logic                 r_neg_q;
    logic                 r_neg_r;
    logic [WORD_BITS-1:0] r_dvs;
    logic [WORD_BITS-1:0] r_quo;
    logic [WORD_BITS-1:0] r_rem;

    logic [WORD_BITS-1:0] dvd_mag;
    logic [WORD_BITS-1:0] dvs_mag;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;

    // operand magnitudes, the most negative value maps to its unsigned pattern
    assign dvd_mag = i_dividend[WORD_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign dvs_mag = i_divisor[WORD_BITS-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // restoring step: shift in next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[WORD_BITS-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_neg_q  <= i_dividend[WORD_BITS-1] ^ i_divisor[WORD_BITS-1];
                r_neg_r  <= i_dividend[WORD_BITS-1];
                r_dvs    <= dvs_mag;
                r_quo    <= dvd_mag;
                r_rem    <= '0;
            end else if (r_active) begin
                if (!diff[WORD_BITS]) begin
                    r_rem <= diff[WORD_BITS-1:0];
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= trial[WORD_BITS-1:0];
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntBits'(WORD_BITS - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    // sign correction of the magnitude results
    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? (~r_quo + 1'b1) : r_quo;
    assign o_remainder = r_neg_r ? (~r_rem + 1'b1) : r_rem;

endmodule

### src/fraction_max_reduce.sv
`timescale 1ns / 1ps
// ============================================================================
// fraction_max_reduce
// Picks the larger of two signed fractions and reduces it by its gcd.
// ============================================================================
// Usage: drive i_num_a, i_den_a, i_num_b, i_den_b and raise start; the
// transaction is taken on a clock edge with start high and busy low. Unless a
// denominator is zero, busy then stays high until the result is out; inputs
// need not be held after that edge. The result appears on o_max_num, o_max_den,
// o_chose_second and o_bad_denominator for exactly one cycle, marked by o_valid,
// and must be taken then: the receiver cannot stall the block.
// Sequence: a zero denominator gives a result in the cycle after the transaction.
// Otherwise the two cross products are formed on the shared multiplier (S_MUL_L,
// S_MUL_R), then compared (S_CMP), then each Euclid remainder and the two
// final divisions run in turn on the shared serial divider. At 32 bits the
// number of Euclid steps is at most about 46. One item is in flight at a
// time. Synchronous reset clears the sequencer and the strobe; no result is
// pending after reset.
// ============================================================================
module fraction_max_reduce #(
    parameter int WORD_BITS = frmr_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_num_a,
    input  logic signed [WORD_BITS-1:0] i_den_a,
    input  logic signed [WORD_BITS-1:0] i_num_b,
    input  logic signed [WORD_BITS-1:0] i_den_b,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_max_num,
    output logic signed [WORD_BITS-1:0] o_max_den,
    output logic                        o_chose_second,
    output logic                        o_bad_denominator
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_CMP,
        S_GCD,
        S_GCD_WAIT,
        S_DIVN,
        S_DIVN_WAIT,
        S_DIVD,
        S_DIVD_WAIT
    } t_state;

    t_state r_state;

    logic signed [WORD_BITS-1:0]   r_num_a, r_den_a, r_num_b, r_den_b;
    logic signed [2*WORD_BITS-1:0] r_lhs, r_rhs;
    logic signed [WORD_BITS-1:0]   r_n, r_d, r_x, r_y;
    logic                          r_valid;
    logic signed [WORD_BITS-1:0]   r_max_num, r_max_den;
    logic                          r_chose_second, r_bad;

    logic signed [WORD_BITS-1:0]   mul_a, mul_b;
    logic signed [2*WORD_BITS-1:0] product;
    logic                          first_bigger;
    logic                          div_start, div_done;
    logic signed [WORD_BITS-1:0]   div_dividend, div_divisor, div_quo, div_rem;

    // shared multiplier for the two cross products
    always_comb begin
        if (r_state == S_MUL_L) begin
            mul_a = r_num_a;
            mul_b = r_den_b;
        end else begin
            mul_a = r_num_b;
            mul_b = r_den_a;
        end
    end
    assign product = mul_a * mul_b;

    // exact compare, sense flips when the denominators differ in sign
    assign first_bigger = (r_den_a[WORD_BITS-1] == r_den_b[WORD_BITS-1]) ?
                          (r_lhs > r_rhs) : (r_lhs < r_rhs);

    // divider operands: euclid step, then numerator and denominator by gcd
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_x;
        div_divisor  = r_y;
        unique case (r_state)
            S_GCD: begin
                div_start = (r_y != '0);
            end
            S_DIVN: begin
                div_start    = 1'b1;
                div_dividend = r_n;
                div_divisor  = r_x;
            end
            S_DIVD: begin
                div_start    = 1'b1;
                div_dividend = r_d;
                div_divisor  = r_x;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    frmr_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_num_a <= i_num_a;
                        r_den_a <= i_den_a;
                        r_num_b <= i_num_b;
                        r_den_b <= i_den_b;
                        if (i_den_a == '0 || i_den_b == '0) begin
                            r_max_num      <= '0;
                            r_max_den      <= '0;
                            r_chose_second <= 1'b0;
                            r_bad          <= 1'b1;
                            r_valid        <= 1'b1;
                        end else begin
                            r_state <= S_MUL_L;
                        end
                    end
                end
                S_MUL_L: begin
                    r_lhs   <= product;
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_rhs   <= product;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_chose_second <= !first_bigger;
                    r_bad          <= 1'b0;
                    if (first_bigger) begin
                        r_n <= r_num_a;
                        r_d <= r_den_a;
                        r_x <= r_num_a;
                        r_y <= r_den_a;
                    end else begin
                        r_n <= r_num_b;
                        r_d <= r_den_b;
                        r_x <= r_num_b;
                        r_y <= r_den_b;
                    end
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    // r_x holds the gcd once the remainder reaches zero
                    if (r_y == '0) begin
                        r_state <= S_DIVN;
                    end else begin
                        r_state <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (div_done) begin
                        r_x     <= r_y;
                        r_y     <= div_rem;
                        r_state <= S_GCD;
                    end
                end
                S_DIVN: begin
                    r_state <= S_DIVN_WAIT;
                end
                S_DIVN_WAIT: begin
                    if (div_done) begin
                        r_max_num <= div_quo;
                        r_state   <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    r_state <= S_DIVD_WAIT;
                end
                S_DIVD_WAIT: begin
                    if (div_done) begin
                        r_max_den <= div_quo;
                        r_valid   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_max_num         = r_max_num;
    assign o_max_den         = r_max_den;
    assign o_chose_second    = r_chose_second;
    assign o_bad_denominator = r_bad;

endmodule
